/* hdl/atcp_pkg.sv */
// ----------------------------------------------------------------------------
// AT command parser package
// Shared widths, status codes and default command names.
// ----------------------------------------------------------------------------
`default_nettype none

package atcp_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned INDEX_W   = 3;
  localparam int unsigned POS_W     = 3;

  // Configuration register file.
  localparam int unsigned NUM_REGS  = 5;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE  = 3'd0,
    ST_ACK   = 3'd1,
    ST_ERROR = 3'd2,
    ST_READ  = 3'd3,
    ST_WRITE = 3'd4
  } status_e;

  // Default names "NAME", "PORT", "VERS", "PUBL", "PWM1".
  localparam logic [REG_W-1:0] NAME_RESET [NUM_REGS] = '{
    32'h4E41_4D45,
    32'h504F_5254,
    32'h5645_5253,
    32'h5055_424C,
    32'h5057_4D31
  };

  // Characters with a meaning in the line syntax.
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54;

endpackage

`default_nettype wire

/* hdl/atcp_if.sv */
// ----------------------------------------------------------------------------
// AT command parser channels
// Valid/ready channels for received characters and parser results.
// ----------------------------------------------------------------------------
`default_nettype none

// One received character per item.
interface atcp_rx_if;
  import atcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// One parser result per item.
interface atcp_res_if;
  import atcp_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  command_index;
  logic [BYTE_W-1:0]   write_value;

  modport source (output valid, output status, output command_index,
                  output write_value, input ready);
  modport sink   (input valid, input status, input command_index,
                  input write_value, output ready);
endinterface

`default_nettype wire

/* hdl/at_command_parser_top.sv */
// ----------------------------------------------------------------------------
// AT command parser
// Recognizes AT, AT+NAME? and AT+NAME=v lines one character per item.
// ----------------------------------------------------------------------------
// Sequence: an accepted character is evaluated in SEQ_EVAL, and its result
// is moved to the output register in SEQ_PUSH. During a command name the
// shared compare unit examines up to NUM_COMMANDS candidates, one per cycle.
// A new character is taken only once the last result has been pushed; a held
// result stalls the sequencer. Reset loads the default names and idles the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module at_command_parser_top #(
  parameter int unsigned NAME_LENGTH  = 4,
  parameter int unsigned NUM_COMMANDS = 5
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [atcp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [atcp_pkg::REG_W-1:0]     cfg_wdata_i,
  atcp_rx_if.sink                             rx_i,
  atcp_res_if.source                          res_o
);
  import atcp_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EVAL,
    SEQ_PUSH
  } seq_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GOT_A,
    PH_MORE,
    PH_NAME,
    PH_RW,
    PH_VALUE
  } phase_e;

  seq_e                 seq_q, seq_d;
  phase_e               phase_q, phase_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [INDEX_W-1:0]   cand_q, cand_d;
  logic [INDEX_W-1:0]   k_q, k_d;
  logic [BYTE_W-1:0]    byte_q;
  logic [BYTE_W-1:0]    held_q, held_d;
  status_e              res_status_q, res_status_d;
  logic [INDEX_W-1:0]   res_index_q, res_index_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [INDEX_W-1:0]   out_index_q, out_index_d;
  logic [BYTE_W-1:0]    out_value_q, out_value_d;
  logic                 rcv_we;
  logic                 hit;

  logic [NAME_LENGTH-1:0][BYTE_W-1:0] rcv_q;
  logic [NAME_LENGTH-1:0][BYTE_W-1:0] cand_chars;

  logic rx_fire;
  logic out_free;

  assign rx_fire  = rx_i.valid && rx_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // Name registers feed the candidate under examination.
  atcp_cfg_regs #(
    .NAME_LENGTH (NAME_LENGTH)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sel_i       (k_q),
    .chars_o     (cand_chars)
  );

  // Shared compare unit, one candidate per cycle.
  atcp_match #(
    .NAME_LENGTH (NAME_LENGTH)
  ) u_match (
    .chars_i (cand_chars),
    .rcv_i   (rcv_q),
    .pos_i   (pos_q),
    .byte_i  (byte_q),
    .hit_o   (hit)
  );

  // Sequencer and line parser.
  always_comb begin
    seq_d        = seq_q;
    phase_d      = phase_q;
    pos_d        = pos_q;
    cand_d       = cand_q;
    k_d          = k_q;
    held_d       = held_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_value_d  = out_value_q;
    rcv_we       = 1'b0;

    case (seq_q)
      SEQ_IDLE: begin
        if (rx_fire) begin
          k_d   = cand_q;
          seq_d = SEQ_EVAL;
        end
      end

      SEQ_EVAL: begin
        // Most characters resolve in this cycle; a name character may loop.
        res_status_d = ST_NONE;
        res_index_d  = '0;
        seq_d        = SEQ_PUSH;
        if (byte_q == CH_LF) begin
          phase_d = PH_IDLE;
          pos_d   = '0;
          cand_d  = '0;
        end else begin
          case (phase_q)
            PH_IDLE: begin
              if (byte_q == CH_A) begin
                phase_d = PH_GOT_A;
                pos_d   = POS_W'(1);
              end
            end
            PH_GOT_A: begin
              if (byte_q == CH_T) begin
                phase_d = PH_MORE;
              end else begin
                phase_d      = PH_IDLE;
                pos_d        = '0;
                cand_d       = '0;
                res_status_d = ST_ERROR;
              end
            end
            PH_MORE: begin
              if (byte_q == CH_PLUS) begin
                phase_d = PH_NAME;
                pos_d   = '0;
                cand_d  = '0;
              end else begin
                phase_d      = PH_IDLE;
                pos_d        = '0;
                cand_d       = '0;
                res_status_d = (byte_q == CH_CR) ? ST_ACK : ST_ERROR;
              end
            end
            PH_NAME: begin
              if ({1'b0, pos_q} >= (POS_W + 1)'(NAME_LENGTH)) begin
                phase_d      = PH_IDLE;
                pos_d        = '0;
                cand_d       = '0;
                res_status_d = ST_ERROR;
              end else if (hit) begin
                cand_d = k_q;
                rcv_we = 1'b1;
                if ({1'b0, pos_q} + (POS_W + 1)'(1) >= (POS_W + 1)'(NAME_LENGTH)) begin
                  phase_d = PH_RW;
                  pos_d   = '0;
                end else begin
                  pos_d = pos_q + POS_W'(1);
                end
              end else if ({1'b0, k_q} >= (INDEX_W + 1)'(NUM_COMMANDS - 1)) begin
                // No candidate left to try.
                phase_d      = PH_IDLE;
                pos_d        = '0;
                cand_d       = '0;
                res_status_d = ST_ERROR;
              end else begin
                k_d   = k_q + INDEX_W'(1);
                seq_d = SEQ_EVAL;
              end
            end
            PH_RW: begin
              if (byte_q == CH_QUERY) begin
                phase_d      = PH_IDLE;
                pos_d        = '0;
                res_status_d = ST_READ;
                res_index_d  = cand_q;
              end else if (byte_q == CH_EQUAL) begin
                phase_d = PH_VALUE;
              end else begin
                phase_d      = PH_IDLE;
                pos_d        = '0;
                cand_d       = '0;
                res_status_d = ST_ERROR;
              end
            end
            PH_VALUE: begin
              held_d       = byte_q;
              phase_d      = PH_IDLE;
              pos_d        = '0;
              res_status_d = ST_WRITE;
              res_index_d  = cand_q;
            end
            default: begin
              phase_d      = PH_IDLE;
              pos_d        = '0;
              cand_d       = '0;
              res_status_d = ST_ERROR;
            end
          endcase
        end
      end

      SEQ_PUSH: begin
        // Move the result into the output register once it is free.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          out_value_d  = held_q;
          seq_d        = SEQ_IDLE;
        end
      end

      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  // Control state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= SEQ_IDLE;
      phase_q      <= PH_IDLE;
      pos_q        <= '0;
      cand_q       <= '0;
      k_q          <= '0;
      held_q       <= '0;
      res_status_q <= ST_NONE;
      res_index_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_NONE;
      out_index_q  <= '0;
      out_value_q  <= '0;
    end else begin
      seq_q        <= seq_d;
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      cand_q       <= cand_d;
      k_q          <= k_d;
      held_q       <= held_d;
      res_status_q <= res_status_d;
      res_index_q  <= res_index_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_value_q  <= out_value_d;
    end
  end

  // Input character and received name characters carry no reset.
  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      byte_q <= rx_i.rx_byte;
    end
    for (int i = 0; i < NAME_LENGTH; i++) begin
      if (rcv_we && pos_q == POS_W'(i)) begin
        rcv_q[i] <= byte_q;
      end
    end
  end

  assign rx_i.ready          = (seq_q == SEQ_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_status_q;
  assign res_o.command_index = out_index_q;
  assign res_o.write_value   = out_value_q;

endmodule

`default_nettype wire

/* hdl/atcp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// AT command parser name registers
// Holds the command names and presents the characters of one selected name.
// ----------------------------------------------------------------------------
`default_nettype none

module atcp_cfg_regs #(
  parameter int unsigned NAME_LENGTH = 4
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [atcp_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire logic [atcp_pkg::REG_W-1:0]                cfg_wdata_i,
  input  wire logic [atcp_pkg::INDEX_W-1:0]              sel_i,
  output logic      [NAME_LENGTH-1:0][atcp_pkg::BYTE_W-1:0] chars_o
);
  import atcp_pkg::*;

  logic [REG_W-1:0] name_q [NUM_REGS];
  logic [REG_W-1:0] sel_word;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        name_q[r] <= NAME_RESET[r];
      end
    end else if (cfg_we_i) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (cfg_idx_i == CFG_IDX_W'(r)) begin
          name_q[r] <= cfg_wdata_i;
        end
      end
    end
  end

  // Select the candidate name; candidates without a register read as zero.
  always_comb begin
    sel_word = '0;
    for (int r = 0; r < NUM_REGS; r++) begin
      if (sel_i == INDEX_W'(r)) begin
        sel_word = name_q[r];
      end
    end
  end

  // The first character sits in the highest byte the name uses.
  for (genvar i = 0; i < NAME_LENGTH; i++) begin : g_char
    localparam int unsigned SH = BYTE_W * (NAME_LENGTH - 1 - i);
    if (SH < REG_W) begin : g_in
      assign chars_o[i] = sel_word[SH +: BYTE_W];
    end else begin : g_out
      assign chars_o[i] = '0;
    end
  end

endmodule

`default_nettype wire

/* hdl/atcp_match.sv */
// ----------------------------------------------------------------------------
// AT command parser name compare unit
// Checks one candidate name against the received prefix and new character.
// ----------------------------------------------------------------------------
`default_nettype none

module atcp_match #(
  parameter int unsigned NAME_LENGTH = 4
) (
  input  wire logic [NAME_LENGTH-1:0][atcp_pkg::BYTE_W-1:0] chars_i,
  input  wire logic [NAME_LENGTH-1:0][atcp_pkg::BYTE_W-1:0] rcv_i,
  input  wire logic [atcp_pkg::POS_W-1:0]                   pos_i,
  input  wire logic [atcp_pkg::BYTE_W-1:0]                  byte_i,
  output logic                                              hit_o
);
  import atcp_pkg::*;

  logic              prefix_ok;
  logic [BYTE_W-1:0] cur_char;

  // Every character before the current position must agree, and the
  // candidate's character at the current position must be the new one.
  always_comb begin
    prefix_ok = 1'b1;
    cur_char  = '0;
    for (int i = 0; i < NAME_LENGTH; i++) begin
      if (POS_W'(i) < pos_i && rcv_i[i] != chars_i[i]) begin
        prefix_ok = 1'b0;
      end
      if (POS_W'(i) == pos_i) begin
        cur_char = chars_i[i];
      end
    end
    hit_o = prefix_ok && (cur_char == byte_i);
  end

endmodule

`default_nettype wire

/* dv/at_command_parser_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT command parser testbench
// Feeds AT, AT+NAME? and AT+NAME=v lines, broken lines and noise through the
// character channel under several sets of command names, predicts every
// parser result and checks each accepted result against the oldest one due.
// ----------------------------------------------------------------------------

module at_command_parser_top_test;
  import atcp_pkg::*;

  localparam int unsigned NAME_LEN     = 4;
  localparam int unsigned NUM_CMDS     = 5;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned ITEMS_PER_SET = 300;
  localparam int unsigned REPORT_MAX   = 10;

  typedef logic [BYTE_W-1:0] char_t;

  // Parser position within a line, as the predictor tracks it.
  typedef enum logic [2:0] {
    LP_IDLE,
    LP_GOT_A,
    LP_GOT_AT,
    LP_NAME,
    LP_MODE,
    LP_VALUE
  } line_phase_e;

  typedef struct {
    status_e            status;
    logic [INDEX_W-1:0] index;
    char_t              value;
  } reply_t;

  // Characters that steer the parser; noise draws on them often.
  localparam char_t SYNTAX_CHARS [7] = '{CH_A, CH_T, CH_PLUS, CH_QUERY, CH_EQUAL,
                                          CH_CR, CH_LF};

  // Predicts the parser reply to each accepted character and checks replies.
  class at_reply_board;
    logic [REG_W-1:0]   names [NUM_CMDS];
    line_phase_e        phase;
    int unsigned        pos;
    logic [INDEX_W-1:0] cand;
    char_t              heard [NAME_LEN];
    char_t              held_value;
    reply_t             expected_replies [$];
    int unsigned        failures;

    function new();
      foreach (names[k]) names[k] = NAME_RESET[k];
      foreach (heard[i]) heard[i] = '0;
      held_value = '0;
      failures   = 0;
      go_idle();
    endfunction

    function void set_name(int unsigned idx, logic [REG_W-1:0] data);
      if (idx < NUM_REGS) names[idx] = data;
    endfunction

    function char_t name_char(int unsigned k, int unsigned i);
      return names[k][8*(NAME_LEN-1-i) +: 8];
    endfunction

    function void go_idle();
      phase = LP_IDLE;
      pos   = 0;
      cand  = '0;
    endfunction

    // A name fits when its prefix equals what was heard and the next char matches.
    function bit name_fits(int unsigned k, char_t c);
      for (int unsigned i = 0; i < pos; i++)
        if (heard[i] != name_char(k, i)) return 1'b0;
      return name_char(k, pos) == c;
    endfunction

    function void take_char(char_t c);
      reply_t      r;
      int unsigned k;
      r.status = ST_NONE;
      r.index  = '0;
      if (c == CH_LF) begin
        go_idle();
      end else begin
        case (phase)
          LP_IDLE: begin
            if (c == CH_A) begin
              phase = LP_GOT_A;
              pos   = 1;
            end
          end
          LP_GOT_A: begin
            if (c == CH_T) begin
              phase = LP_GOT_AT;
            end else begin
              go_idle();
              r.status = ST_ERROR;
            end
          end
          LP_GOT_AT: begin
            if (c == CH_PLUS) begin
              phase = LP_NAME;
              pos   = 0;
              cand  = '0;
            end else begin
              go_idle();
              r.status = (c == CH_CR) ? ST_ACK : ST_ERROR;
            end
          end
          LP_NAME: begin
            // Search upward from the current candidate.
            k = cand;
            while (k < NUM_CMDS && !name_fits(k, c)) k++;
            if (k >= NUM_CMDS) begin
              go_idle();
              r.status = ST_ERROR;
            end else begin
              cand       = INDEX_W'(k);
              heard[pos] = c;
              if (pos + 1 >= NAME_LEN) begin
                phase = LP_MODE;
                pos   = 0;
              end else begin
                pos++;
              end
            end
          end
          LP_MODE: begin
            if (c == CH_QUERY) begin
              phase    = LP_IDLE;
              pos      = 0;
              r.status = ST_READ;
              r.index  = cand;
            end else if (c == CH_EQUAL) begin
              phase = LP_VALUE;
            end else begin
              go_idle();
              r.status = ST_ERROR;
            end
          end
          LP_VALUE: begin
            held_value = c;
            phase      = LP_IDLE;
            pos        = 0;
            r.status   = ST_WRITE;
            r.index    = cand;
          end
          default: begin
            go_idle();
            r.status = ST_ERROR;
          end
        endcase
      end
      r.value = held_value;
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                              char_t val);
      reply_t e;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("ERROR: unexpected result status=%0d index=%0d value=%02h",
                   st, idx, val);
        return;
      end
      e = expected_replies.pop_front();
      if (st !== e.status || idx !== e.index || val !== e.value) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("ERROR: result mismatch: status %0d/%0d index %0d/%0d value %02h/%02h %s",
                   e.status, st, e.index, idx, e.value, val, "(expected/actual)");
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_wdata_i;

  atcp_rx_if  rx_ch ();
  atcp_res_if res_ch ();

  at_reply_board board = new();
  int unsigned   burst_left = 0;
  char_t         line_buf [$];

  at_command_parser_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_ch),
    .res_o       (res_ch)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready)
      board.check_reply(res_ch.status, res_ch.command_index, res_ch.write_value);
  end

  // Watchdog.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Result side: stalls on a changing pattern, and once holds off for a long
  // stretch so that the parser backs up into its input.
  initial begin : result_sink
    int unsigned cyc;
    int unsigned taken;
    int unsigned hold_left;
    bit          held_once;
    cyc          = 0;
    taken        = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (res_ch.valid && res_ch.ready) taken++;
      if (!held_once && taken == 150) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case ((cyc / 101) % 5)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(3) != 0);
          2:       res_ch.ready <= ($urandom_range(3) == 0);
          3:       res_ch.ready <= (cyc % 3 == 0);
          default: res_ch.ready <= $urandom_range(1);
        endcase
      end
    end
  end

  // Offer one character; the sender works in bursts with random gaps.
  task automatic send_char(char_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= c;
    do @(posedge clk_i); while (!(rx_ch.valid && rx_ch.ready));
    board.take_char(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(char_t'(s[i]));
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic drain_replies();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.expected_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write the five names, plus writes to the unused indexes that must be ignored.
  task automatic load_names(logic [REG_W-1:0] n0, logic [REG_W-1:0] n1,
                            logic [REG_W-1:0] n2, logic [REG_W-1:0] n3,
                            logic [REG_W-1:0] n4);
    logic [REG_W-1:0] set [NUM_CMDS];
    logic [REG_W-1:0] junk;
    set = '{n0, n1, n2, n3, n4};
    for (int unsigned k = 0; k < NUM_CMDS; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(k);
      cfg_wdata_i <= set[k];
      @(posedge clk_i);
      board.set_name(k, set[k]);
    end
    for (int unsigned j = NUM_REGS; j < (1 << CFG_IDX_W); j++) begin
      junk        = $urandom;
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(j);
      cfg_wdata_i <= junk;
      @(posedge clk_i);
      board.set_name(j, junk);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic char_t pick_char();
    if ($urandom_range(1) == 0) return char_t'($urandom_range(255));
    return SYNTAX_CHARS[$urandom_range(6)];
  endfunction

  // Build one random line into line_buf: mostly well formed, some broken.
  task automatic build_line();
    int unsigned r;
    int unsigned k;
    int unsigned cut;
    r = $urandom_range(99);
    k = $urandom_range(NUM_CMDS - 1);
    line_buf.delete();
    if (r >= 93) begin
      // Noise.
      repeat ($urandom_range(1, 4)) line_buf.push_back(pick_char());
      return;
    end
    line_buf.push_back(CH_A);
    line_buf.push_back(CH_T);
    if (r < 12) begin
      line_buf.push_back(CH_CR);
    end else begin
      line_buf.push_back(CH_PLUS);
      for (int unsigned i = 0; i < NAME_LEN; i++) line_buf.push_back(board.name_char(k, i));
      if ($urandom_range(1) == 0) begin
        line_buf.push_back(CH_QUERY);
      end else begin
        line_buf.push_back(CH_EQUAL);
        line_buf.push_back(char_t'($urandom_range(255)));
      end
    end
    if (r >= 70 && r < 84) begin
      // One character replaced.
      line_buf[$urandom_range(line_buf.size() - 1)] = pick_char();
    end else if (r >= 84) begin
      // Line cut short, then a stray character or a line feed.
      cut = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > cut) void'(line_buf.pop_back());
      line_buf.push_back(($urandom_range(2) == 0) ? CH_LF : pick_char());
    end
  endtask

  // Random lines until about n characters have been sent; one pause midway
  // lets every outstanding result come back first.
  task automatic run_lines(int unsigned n);
    int unsigned sent;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      build_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
      sent += line_buf.size();
      if (!paused && sent >= n / 2) begin
        paused = 1'b1;
        drain_replies();
      end
    end
    drain_replies();
  endtask

  // Names that share prefixes, so the upward search has to skip candidates.
  task automatic load_shared_prefixes();
    logic [REG_W-1:0] p;
    logic [REG_W-1:0] a;
    logic [REG_W-1:0] b;
    logic [REG_W-1:0] c;
    p = $urandom;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    load_names({p[31:8], a[7:0]}, {p[31:8], b[7:0]}, {p[31:16], c[15:0]},
               {p[31:24], a[23:0]}, {p[31:8], a[7:0]});
  endtask

  // Stimulus.
  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines with the default names.
    send_text("AT");
    send_char(CH_CR);
    send_text("AT+PUBL?");
    send_text("AT+PWM1=");
    send_char(8'hFF);
    send_text("B");
    send_text("AX");
    send_text("AT+Q");
    send_text("A");
    send_char(CH_LF);
    drain_replies();
    run_lines(ITEMS_PER_SET);

    // Extreme names: all zeros, all ones, syntax characters, single 0xFF bytes.
    load_names(32'h0000_0000, 32'hFFFF_FFFF, {CH_LF, CH_CR, CH_QUERY, CH_EQUAL},
               32'h0000_00FF, 32'hFF00_0000);
    run_lines(ITEMS_PER_SET);

    load_shared_prefixes();
    run_lines(ITEMS_PER_SET);

    load_names($urandom, $urandom, $urandom, $urandom, $urandom);
    run_lines(ITEMS_PER_SET);

    load_shared_prefixes();
    run_lines(ITEMS_PER_SET);

    load_names(NAME_RESET[0], NAME_RESET[1], NAME_RESET[2], NAME_RESET[3],
               NAME_RESET[4]);
    run_lines(ITEMS_PER_SET);

    drain_replies();
    if (board.failures == 0 && board.expected_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/atcp_pkg.sv
hdl/atcp_if.sv
hdl/atcp_cfg_regs.sv
hdl/atcp_match.sv
hdl/at_command_parser_top.sv
dv/at_command_parser_top_test.sv
